// ===== rtl/per_pkg.sv =====
// per_pkg: shared constants, types and fixed-point helpers for the point rotation block
// no dependencies; imported by per_trig, per_rotate, point_euler_rotation_top and per_checker
`timescale 1ns / 1ps

package per_pkg;

  // default widths of coordinates and binary angles
  localparam int COORD_WIDTH = 32;
  localparam int ANGLE_WIDTH = 16;

  // trig magnitudes are unsigned q.29 and never exceed one
  localparam int TRIG_W = 30;
  localparam int SC_W   = TRIG_W + 1;
  localparam int PROD_W = 2 * TRIG_W;
  localparam int RCP_W  = 32;

  // series terms and pipeline depths
  localparam int NTERMS   = 5;
  localparam int TRIG_LAT = 2 * NTERMS + 5;
  localparam int ROT_LAT  = 3;
  localparam int PIPE_LAT = TRIG_LAT + 3 * ROT_LAT;

  localparam logic [TRIG_W-1:0] TRIG_ONE  = 30'd536870912;
  localparam logic [TRIG_W-1:0] TRIG_HALF = 30'd268435456;
  localparam logic [TRIG_W:0]   TRIG_TURN = 31'd1073741824;
  localparam logic [30:0]       PI_Q29    = 31'd1686629713;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_YAW,
    REG_PITCH,
    REG_ROLL
  } reg_idx_e;

  // series divisors and their reciprocals, floor(2^32 / k)
  typedef logic [6:0] div_k_t;
  localparam div_k_t KS [NTERMS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  localparam div_k_t KC [NTERMS] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
  localparam logic [RCP_W-1:0] RS [NTERMS] = '{
    32'd39045157, 32'd59652323, 32'd102261126, 32'd214748364, 32'd715827882
  };
  localparam logic [RCP_W-1:0] RC [NTERMS] = '{
    32'd47721858, 32'd76695844, 32'd143165576, 32'd357913941, 32'd2147483648
  };

  // sine, negated sine and cosine of one angle
  typedef struct packed {
    logic signed [SC_W-1:0] sn;
    logic signed [SC_W-1:0] ns;
    logic signed [SC_W-1:0] cs;
  } trig_t;

  // round a q.58 product to q.29
  function automatic logic [TRIG_W-1:0] rnd29(input logic [PROD_W-1:0] p);
    logic [PROD_W-1:0] s;
    s = p + PROD_W'(TRIG_HALF);
    return s[29 +: TRIG_W];
  endfunction

  // q.29 product rounded to nearest
  function automatic logic [TRIG_W-1:0] qmul(input logic [TRIG_W-1:0] a,
                                             input logic [TRIG_W-1:0] b);
    return rnd29(PROD_W'(a) * PROD_W'(b));
  endfunction

  // fix the reciprocal quotient estimate and form one minus the quotient
  function automatic logic [TRIG_W-1:0] next_term(input logic [TRIG_W-1:0] v,
                                                  input logic [TRIG_W-1:0] qe,
                                                  input div_k_t k);
    logic [TRIG_W-1:0] rem;
    logic [TRIG_W-1:0] q;
    rem = v - TRIG_W'(qe * TRIG_W'(k));
    q   = (rem >= TRIG_W'(k)) ? qe + 1'b1 : qe;
    return TRIG_ONE - q;
  endfunction

endpackage

// ===== rtl/point_euler_rotation_top.sv =====
// point_euler_rotation_top: yaw, pitch, roll rotation of Q16.16 points
// depends on per_pkg, per_trig and per_rotate
`timescale 1ns / 1ps

// Takes one point per clock on start_i and gives the rotated point on out_*_o,
// marked by done_o for one cycle. The receiver cannot stall, so busy_o stays
// low and a point may enter on every cycle. The latency is set by the sine and
// cosine pipelines (15 stages: angle scaling, square, five series terms of two
// stages each, final term, sine product and quadrant mapping), which the point
// waits out in a delay line, followed by three rotation stages. Angles must be
// written on the cfg port while no point is in flight; the block does not
// enforce this. A point may start on the cycle after the write.
module point_euler_rotation_top
  import per_pkg::*;
#(
  parameter int COORD_WIDTH = per_pkg::COORD_WIDTH,
  parameter int ANGLE_WIDTH = per_pkg::ANGLE_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [ANGLE_WIDTH-1:0]        cfg_data_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] in_x_i,
  input  logic signed [COORD_WIDTH-1:0] in_y_i,
  input  logic signed [COORD_WIDTH-1:0] in_z_i,
  output logic                          done_o,
  output logic signed [COORD_WIDTH-1:0] out_x_o,
  output logic signed [COORD_WIDTH-1:0] out_y_o,
  output logic signed [COORD_WIDTH-1:0] out_z_o
);

  localparam int NDLY = TRIG_LAT;

  // angle registers
  logic [ANGLE_WIDTH-1:0] yaw_q, pitch_q, roll_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_q   <= '0;
      pitch_q <= '0;
      roll_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_YAW:   yaw_q   <= cfg_data_i;
        REG_PITCH: pitch_q <= cfg_data_i;
        REG_ROLL:  roll_q  <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // sine and cosine of each angle
  trig_t yaw_t, pitch_t, roll_t, pitch_neg;

  per_trig #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_trig_yaw (
    .clk_i(clk_i), .angle_i(yaw_q), .trig_o(yaw_t)
  );
  per_trig #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_trig_pitch (
    .clk_i(clk_i), .angle_i(pitch_q), .trig_o(pitch_t)
  );
  per_trig #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_trig_roll (
    .clk_i(clk_i), .angle_i(roll_q), .trig_o(roll_t)
  );

  // pitch turns the other way round in the x-z plane
  always_comb begin
    pitch_neg.sn = pitch_t.ns;
    pitch_neg.ns = pitch_t.sn;
    pitch_neg.cs = pitch_t.cs;
  end

  // transaction accept and point delay line
  logic accept;
  logic [NDLY-1:0] dv_q;
  logic signed [COORD_WIDTH-1:0] dx_q [NDLY];
  logic signed [COORD_WIDTH-1:0] dy_q [NDLY];
  logic signed [COORD_WIDTH-1:0] dz_q [NDLY];

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else begin
      dv_q <= {dv_q[NDLY-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q[0] <= in_x_i;
    dy_q[0] <= in_y_i;
    dz_q[0] <= in_z_i;
    for (int i = 1; i < NDLY; i++) begin
      dx_q[i] <= dx_q[i-1];
      dy_q[i] <= dy_q[i-1];
      dz_q[i] <= dz_q[i-1];
    end
  end

  // yaw: x, y about z
  logic                          v1, v2, v3;
  logic signed [COORD_WIDTH-1:0] x1, y1, z1, x2, z2, y2, y3, z3, x3;

  per_rotate #(.COORD_WIDTH(COORD_WIDTH)) u_rot_yaw (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(dv_q[NDLY-1]),
    .a_i(dx_q[NDLY-1]), .b_i(dy_q[NDLY-1]), .c_i(dz_q[NDLY-1]),
    .trig_i(yaw_t), .valid_o(v1), .o1_o(x1), .o2_o(y1), .c_o(z1)
  );

  // pitch: x, z about y
  per_rotate #(.COORD_WIDTH(COORD_WIDTH)) u_rot_pitch (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(v1),
    .a_i(x1), .b_i(z1), .c_i(y1),
    .trig_i(pitch_neg), .valid_o(v2), .o1_o(x2), .o2_o(z2), .c_o(y2)
  );

  // roll: y, z about x
  per_rotate #(.COORD_WIDTH(COORD_WIDTH)) u_rot_roll (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(v2),
    .a_i(y2), .b_i(z2), .c_i(x2),
    .trig_i(roll_t), .valid_o(v3), .o1_o(y3), .o2_o(z3), .c_o(x3)
  );

  assign done_o  = v3;
  assign out_x_o = x3;
  assign out_y_o = y3;
  assign out_z_o = z3;

endmodule

// ===== rtl/per_trig.sv =====
// per_trig: free-running sine and cosine pipeline for one binary angle
// depends on per_pkg (constants, qmul, next_term, trig_t)
`timescale 1ns / 1ps

module per_trig
  import per_pkg::*;
#(
  parameter int ANGLE_WIDTH = per_pkg::ANGLE_WIDTH
) (
  input  logic                   clk_i,
  input  logic [ANGLE_WIDTH-1:0] angle_i,
  output trig_t                  trig_o
);

  localparam int XP_W = TRIG_W + 31;
  localparam int EP_W = TRIG_W + RCP_W;

  // octant folding of the angle scaled to a 32-bit turn
  logic [31:0]       turn;
  logic [TRIG_W-1:0] r;
  logic              swap;
  logic [TRIG_W-1:0] rf;
  logic [XP_W-1:0]   xp;

  assign turn = {angle_i, {(32 - ANGLE_WIDTH){1'b0}}};
  assign r    = turn[TRIG_W-1:0];
  assign swap = r > TRIG_ONE;
  assign rf   = swap ? TRIG_W'(TRIG_TURN - {1'b0, r}) : r;
  assign xp   = XP_W'(rf) * XP_W'(PI_Q29);

  // stage 1: angle in radians, stage 2: its square
  logic [TRIG_W-1:0] x1_q, x2x_q, x2_q;
  logic              sw1_q, sw2_q;
  logic [1:0]        qd1_q, qd2_q;

  always_ff @(posedge clk_i) begin
    x1_q  <= xp[31 +: TRIG_W];
    sw1_q <= swap;
    qd1_q <= turn[31:30];
    x2_q  <= qmul(x1_q, x1_q);
    x2x_q <= x1_q;
    sw2_q <= sw1_q;
    qd2_q <= qd1_q;
  end

  // series terms: product stage then reciprocal estimate stage
  logic [PROD_W-1:0] prs_q [NTERMS];
  logic [PROD_W-1:0] prc_q [NTERMS];
  logic [TRIG_W-1:0] xa_q  [NTERMS];
  logic [TRIG_W-1:0] x2a_q [NTERMS];
  logic              swa_q [NTERMS];
  logic [1:0]        qda_q [NTERMS];
  logic [TRIG_W-1:0] vs_q  [NTERMS];
  logic [TRIG_W-1:0] vc_q  [NTERMS];
  logic [TRIG_W-1:0] qs_q  [NTERMS];
  logic [TRIG_W-1:0] qc_q  [NTERMS];
  logic [TRIG_W-1:0] xb_q  [NTERMS];
  logic [TRIG_W-1:0] x2b_q [NTERMS];
  logic              swb_q [NTERMS];
  logic [1:0]        qdb_q [NTERMS];

  logic [TRIG_W-1:0] tin_s [NTERMS];
  logic [TRIG_W-1:0] tin_c [NTERMS];
  logic [TRIG_W-1:0] xin   [NTERMS];
  logic [TRIG_W-1:0] x2in  [NTERMS];
  logic              swin  [NTERMS];
  logic [1:0]        qdin  [NTERMS];
  logic [TRIG_W-1:0] vs_d  [NTERMS];
  logic [TRIG_W-1:0] vc_d  [NTERMS];
  logic [EP_W-1:0]   es    [NTERMS];
  logic [EP_W-1:0]   ec    [NTERMS];

  // operand selection and quotient estimate for each term
  always_comb begin
    for (int i = 0; i < NTERMS; i++) begin
      if (i == 0) begin
        tin_s[i] = TRIG_ONE;
        tin_c[i] = TRIG_ONE;
        xin[i]   = x2x_q;
        x2in[i]  = x2_q;
        swin[i]  = sw2_q;
        qdin[i]  = qd2_q;
      end else begin
        tin_s[i] = next_term(vs_q[i-1], qs_q[i-1], KS[i-1]);
        tin_c[i] = next_term(vc_q[i-1], qc_q[i-1], KC[i-1]);
        xin[i]   = xb_q[i-1];
        x2in[i]  = x2b_q[i-1];
        swin[i]  = swb_q[i-1];
        qdin[i]  = qdb_q[i-1];
      end
      vs_d[i] = rnd29(prs_q[i]);
      vc_d[i] = rnd29(prc_q[i]);
      es[i]   = EP_W'(vs_d[i]) * EP_W'(RS[i]);
      ec[i]   = EP_W'(vc_d[i]) * EP_W'(RC[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NTERMS; i++) begin
      prs_q[i] <= PROD_W'(x2in[i]) * PROD_W'(tin_s[i]);
      prc_q[i] <= PROD_W'(x2in[i]) * PROD_W'(tin_c[i]);
      xa_q[i]  <= xin[i];
      x2a_q[i] <= x2in[i];
      swa_q[i] <= swin[i];
      qda_q[i] <= qdin[i];
      vs_q[i]  <= vs_d[i];
      vc_q[i]  <= vc_d[i];
      qs_q[i]  <= es[i][RCP_W +: TRIG_W];
      qc_q[i]  <= ec[i][RCP_W +: TRIG_W];
      xb_q[i]  <= xa_q[i];
      x2b_q[i] <= x2a_q[i];
      swb_q[i] <= swa_q[i];
      qdb_q[i] <= qda_q[i];
    end
  end

  // final term fix-up, sine product, then quadrant mapping
  logic [TRIG_W-1:0] ts_q, tc_q, xf_q, s0_q, c0_q;
  logic              swf_q, swg_q;
  logic [1:0]        qdf_q, qdg_q;

  always_ff @(posedge clk_i) begin
    ts_q  <= next_term(vs_q[NTERMS-1], qs_q[NTERMS-1], KS[NTERMS-1]);
    tc_q  <= next_term(vc_q[NTERMS-1], qc_q[NTERMS-1], KC[NTERMS-1]);
    xf_q  <= xb_q[NTERMS-1];
    swf_q <= swb_q[NTERMS-1];
    qdf_q <= qdb_q[NTERMS-1];
    s0_q  <= qmul(xf_q, ts_q);
    c0_q  <= tc_q;
    swg_q <= swf_q;
    qdg_q <= qdf_q;
  end

  logic signed [SC_W-1:0] sp, cp, sm, cm;
  trig_t                  trig_d, trig_q;

  always_comb begin
    sp = swg_q ? signed'({1'b0, c0_q}) : signed'({1'b0, s0_q});
    cp = swg_q ? signed'({1'b0, s0_q}) : signed'({1'b0, c0_q});
    sm = -sp;
    cm = -cp;
    case (qdg_q)
      2'd0:    begin trig_d.sn = sp; trig_d.cs = cp; end
      2'd1:    begin trig_d.sn = cp; trig_d.cs = sm; end
      2'd2:    begin trig_d.sn = sm; trig_d.cs = cm; end
      default: begin trig_d.sn = cm; trig_d.cs = sp; end
    endcase
    trig_d.ns = -trig_d.sn;
  end

  always_ff @(posedge clk_i) begin
    trig_q <= trig_d;
  end

  assign trig_o = trig_q;

endmodule

// ===== rtl/per_rotate.sv =====
// per_rotate: three-stage plane rotation o1 = a*c - b*s, o2 = a*s + b*c, with rounding
// and saturation; depends on per_pkg (trig_t, TRIG_HALF, SC_W)
`timescale 1ns / 1ps

module per_rotate
  import per_pkg::*;
#(
  parameter int COORD_WIDTH = per_pkg::COORD_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH-1:0] a_i,
  input  logic signed [COORD_WIDTH-1:0] b_i,
  input  logic signed [COORD_WIDTH-1:0] c_i,
  input  trig_t                         trig_i,
  output logic                          valid_o,
  output logic signed [COORD_WIDTH-1:0] o1_o,
  output logic signed [COORD_WIDTH-1:0] o2_o,
  output logic signed [COORD_WIDTH-1:0] c_o
);

  localparam int PP_W = COORD_WIDTH + 16;
  localparam int HL_W = PP_W + 1;
  localparam int SUM_W = COORD_WIDTH + 33;
  localparam logic signed [SUM_W-1:0] RND_C = SUM_W'(TRIG_HALF);
  localparam logic signed [SUM_W-1:0] MAX_C =
    {{(SUM_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] MIN_C = ~MAX_C;

  // split trig values into a signed high part and a 15-bit low part
  logic signed [15:0] cs_h, cs_l, sn_h, sn_l, ns_h, ns_l;

  assign cs_h = trig_i.cs[SC_W-1:15];
  assign cs_l = signed'({1'b0, trig_i.cs[14:0]});
  assign sn_h = trig_i.sn[SC_W-1:15];
  assign sn_l = signed'({1'b0, trig_i.sn[14:0]});
  assign ns_h = trig_i.ns[SC_W-1:15];
  assign ns_l = signed'({1'b0, trig_i.ns[14:0]});

  // stage 1: partial products
  logic signed [PP_W-1:0] p1ah_q, p1al_q, p1bh_q, p1bl_q;
  logic signed [PP_W-1:0] p2ah_q, p2al_q, p2bh_q, p2bl_q;
  logic signed [COORD_WIDTH-1:0] c1_q, c2_q;

  always_ff @(posedge clk_i) begin
    p1ah_q <= a_i * cs_h;
    p1al_q <= a_i * cs_l;
    p1bh_q <= b_i * ns_h;
    p1bl_q <= b_i * ns_l;
    p2ah_q <= a_i * sn_h;
    p2al_q <= a_i * sn_l;
    p2bh_q <= b_i * cs_h;
    p2bl_q <= b_i * cs_l;
    c1_q   <= c_i;
  end

  // stage 2: high and low sums
  logic signed [HL_W-1:0] h1_q, l1_q, h2_q, l2_q;

  always_ff @(posedge clk_i) begin
    h1_q <= HL_W'(p1ah_q) + HL_W'(p1bh_q);
    l1_q <= HL_W'(p1al_q) + HL_W'(p1bl_q);
    h2_q <= HL_W'(p2ah_q) + HL_W'(p2bh_q);
    l2_q <= HL_W'(p2al_q) + HL_W'(p2bl_q);
    c2_q <= c1_q;
  end

  // stage 3: recombine, round to nearest, saturate
  function automatic logic signed [COORD_WIDTH-1:0] finish(
    input logic signed [HL_W-1:0] h,
    input logic signed [HL_W-1:0] l
  );
    logic signed [SUM_W-1:0] tot;
    logic signed [SUM_W-1:0] sh;
    tot = (SUM_W'(h) <<< 15) + SUM_W'(l) + RND_C;
    sh  = tot >>> 29;
    if (sh > MAX_C) begin
      return MAX_C[COORD_WIDTH-1:0];
    end else if (sh < MIN_C) begin
      return MIN_C[COORD_WIDTH-1:0];
    end
    return sh[COORD_WIDTH-1:0];
  endfunction

  logic signed [COORD_WIDTH-1:0] o1_q, o2_q, c3_q;

  always_ff @(posedge clk_i) begin
    o1_q <= finish(h1_q, l1_q);
    o2_q <= finish(h2_q, l2_q);
    c3_q <= c2_q;
  end

  // valid travels with the data
  logic [ROT_LAT-1:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[ROT_LAT-2:0], valid_i};
    end
  end

  assign valid_o = v_q[ROT_LAT-1];
  assign o1_o    = o1_q;
  assign o2_o    = o2_q;
  assign c_o     = c3_q;

endmodule

// ===== rtl/per_checker.sv =====
// per_checker: port-level checks of the point rotation top, bound into it
// depends on per_pkg (PIPE_LAT) and point_euler_rotation_top
`timescale 1ns / 1ps

module per_checker
  import per_pkg::*;
#(
  parameter int COORD_WIDTH = per_pkg::COORD_WIDTH
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic signed [COORD_WIDTH-1:0] in_x_i,
  input logic signed [COORD_WIDTH-1:0] in_y_i,
  input logic signed [COORD_WIDTH-1:0] in_z_i,
  input logic                          done_o,
  input logic signed [COORD_WIDTH-1:0] out_x_o,
  input logic signed [COORD_WIDTH-1:0] out_y_o,
  input logic signed [COORD_WIDTH-1:0] out_z_o
);

  localparam int CNT_W = $clog2(PIPE_LAT + 1);

  // cycles since reset, saturating at the pipeline latency
  logic [CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cnt_q != CNT_W'(PIPE_LAT)) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  logic warm;
  assign warm = cnt_q == CNT_W'(PIPE_LAT);

  // one result per accepted transaction, a fixed latency later
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    warm |-> (done_o == $past(start_i && !busy_o, PIPE_LAT)))
    else $error("result strobe does not match accepted transaction");

  // the origin stays at the origin
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && $past(start_i && !busy_o && in_x_i == 0 && in_y_i == 0 && in_z_i == 0,
                   PIPE_LAT))
    |-> (out_x_o == 0 && out_y_o == 0 && out_z_o == 0))
    else $error("origin did not map to origin");

  // the block never holds off a transaction
  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_o)
    else $error("busy raised");

endmodule

bind point_euler_rotation_top per_checker #(.COORD_WIDTH(COORD_WIDTH)) u_per_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
  .in_x_i(in_x_i), .in_y_i(in_y_i), .in_z_i(in_z_i), .done_o(done_o),
  .out_x_o(out_x_o), .out_y_o(out_y_o), .out_z_o(out_z_o)
);

// ===== verif/tb_point_euler_rotation_top.sv =====
// tb_point_euler_rotation_top: self-checking bench for the zyx point rotation block
// depends on per_pkg and point_euler_rotation_top; holds its own fixed-point rotation predictor
`timescale 1ns / 1ps

module tb_point_euler_rotation_top;
  import per_pkg::*;

  localparam int LAT       = PIPE_LAT + 4;
  localparam int WDOG_MAX  = 2000;
  localparam int N_RAND    = 1150;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_YAW;
  logic [15:0]          cfg_data_i = '0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic signed [31:0]   in_x_i = '0, in_y_i = '0, in_z_i = '0;
  logic                 done_o;
  logic signed [31:0]   out_x_o, out_y_o, out_z_o;

  point_t     pending_pts[$];
  point_t     rotated_q[$];
  logic [15:0] ang_yaw, ang_pitch, ang_roll;
  int unsigned n_mismatch = 0, n_points = 0, n_results = 0, n_settings = 0;
  int unsigned idle_cycles = 0;
  int          burst_left = 0, gap_left = 0;

  point_euler_rotation_top u_top (.*);

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // q.29 product rounded to nearest
  function automatic longint unsigned q29_mul(longint unsigned a, longint unsigned b);
    return (a * b + 64'd268435456) >> 29;
  endfunction

  // sine and cosine of a binary angle in q.29 by octant folding and series
  function automatic void angle_trig(input logic [15:0] ang, output longint sn,
                                     output longint cs);
    longint unsigned ks[5] = '{110, 72, 42, 20, 6};
    longint unsigned kc[5] = '{90, 56, 30, 12, 2};
    longint unsigned u, r, xr, x2, ts, tc, s0, c0, tmp;
    logic [1:0] quad;
    bit swap;
    u = 64'({ang, 16'h0});
    quad = u[31:30];
    r = u & 64'h3FFF_FFFF;
    swap = r > 64'd536870912;
    if (swap) r = 64'h4000_0000 - r;
    xr = (r * 64'd1686629713) >> 31;
    x2 = q29_mul(xr, xr);
    ts = 64'd536870912;
    tc = 64'd536870912;
    for (int i = 0; i < 5; i++) begin
      ts = 64'd536870912 - q29_mul(x2, ts) / ks[i];
      tc = 64'd536870912 - q29_mul(x2, tc) / kc[i];
    end
    s0 = q29_mul(xr, ts);
    c0 = tc;
    if (swap) begin
      tmp = s0; s0 = c0; c0 = tmp;
    end
    case (quad)
      2'd0: begin sn = s0;  cs = c0;  end
      2'd1: begin sn = c0;  cs = -longint'(s0); end
      2'd2: begin sn = -longint'(s0); cs = -longint'(c0); end
      default: begin sn = -longint'(c0); cs = s0; end
    endcase
  endfunction

  // round((a*p + b*q) / 2^29) exactly, ties up, saturated to 32 bits
  function automatic logic signed [31:0] mix_round(longint a, longint p, longint b, longint q);
    logic signed [127:0] acc;
    acc = 128'(signed'(a)) * 128'(signed'(p)) + 128'(signed'(b)) * 128'(signed'(q));
    acc = (acc + 128'sd268435456) >>> 29;
    if (acc > 128'sd2147483647) return 32'sh7FFF_FFFF;
    if (acc < -128'sd2147483648) return 32'sh8000_0000;
    return acc[31:0];
  endfunction

  // rotate about z, then y, then x
  function automatic point_t rotate_zyx(point_t p);
    longint s, c, x, y, z, nx;
    x = longint'(p.x); y = longint'(p.y); z = longint'(p.z);
    angle_trig(ang_yaw, s, c);
    nx = longint'(mix_round(x, c, y, -s));
    y  = longint'(mix_round(x, s, y, c));
    x  = nx;
    angle_trig(ang_pitch, s, c);
    nx = longint'(mix_round(x, c, z, s));
    z  = longint'(mix_round(z, c, x, -s));
    x  = nx;
    angle_trig(ang_roll, s, c);
    nx = longint'(mix_round(y, c, z, -s));
    z  = longint'(mix_round(y, s, z, c));
    y  = nx;
    return '{x[31:0], y[31:0], z[31:0]};
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
      1: return 32'sh8000_0000 + $urandom_range(0, 3);
      2: return $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
      default: return $urandom;
    endcase
  endfunction

  // driver: bursts and gaps; expectations formed at acceptance
  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) begin
      rotated_q.push_back(rotate_zyx('{in_x_i, in_y_i, in_z_i}));
      n_points++;
    end
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (start_i && busy_o) begin
      // hold the current transaction
    end else if (gap_left > 0) begin
      gap_left--;
      start_i <= 1'b0;
    end else if (pending_pts.size() > 0) begin
      point_t p;
      p = pending_pts.pop_front();
      start_i <= 1'b1;
      in_x_i <= p.x; in_y_i <= p.y; in_z_i <= p.z;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 30);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      start_i <= 1'b0;
    end
  end

  // monitor: compare each result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      point_t e;
      n_results++;
      if (rotated_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %h %h %h", out_x_o, out_y_o, out_z_o);
      end else begin
        e = rotated_q.pop_front();
        if (e.x !== out_x_o || e.y !== out_y_o || e.z !== out_z_o) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch exp %h %h %h got %h %h %h (angles %h %h %h)",
                     e.x, e.y, e.z, out_x_o, out_y_o, out_z_o,
                     ang_yaw, ang_pitch, ang_roll);
        end
      end
    end
  end

  // watchdog on cycles with no transaction either way
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("watchdog expired");
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic set_angle(reg_idx_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_YAW:   ang_yaw = val;
      REG_PITCH: ang_pitch = val;
      default:   ang_roll = val;
    endcase
  endtask

  task automatic set_angles(logic [15:0] y, logic [15:0] p, logic [15:0] r);
    set_angle(REG_YAW, y);
    set_angle(REG_PITCH, p);
    set_angle(REG_ROLL, r);
    n_settings++;
  endtask

  // wait until the pipeline is empty
  task automatic drain();
    wait (pending_pts.size() == 0 && !start_i);
    wait (rotated_q.size() == 0);
    repeat (LAT) @(posedge clk_i);
  endtask

  task automatic queue_point(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
    pending_pts.push_back('{x, y, z});
  endtask

  initial begin
    logic [15:0] corner[8] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000,
                               16'hC000, 16'h2000, 16'h1FFF, 16'h2001};
    ang_yaw = '0; ang_pitch = '0; ang_roll = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: identity, extremes, octant edges
    queue_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0);
    queue_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    queue_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    queue_point(32'sh0001_0000, 32'sh0, 32'sh0);
    drain();
    for (int i = 0; i < 8; i++) begin
      set_angles(corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8]);
      queue_point(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000);
      queue_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
      drain();
    end

    // random phases with random angles and extreme settings mixed in
    for (int ph = 0; ph < 23; ph++) begin
      if (ph % 6 == 0)
        set_angles(corner[$urandom_range(0, 7)], corner[$urandom_range(0, 7)],
                   corner[$urandom_range(0, 7)]);
      else
        set_angles(16'($urandom), 16'($urandom), 16'($urandom));
      for (int i = 0; i < N_RAND / 23; i++)
        queue_point(rand_coord(), rand_coord(), rand_coord());
      drain();
    end

    $display("rotated %0d points over %0d angle settings, %0d results checked",
             n_points, n_settings, n_results);
    if (n_mismatch == 0 && rotated_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", n_mismatch, rotated_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
